FILE: src/totp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the TOTP unit.
package totp_pkg;

  // Field widths
  localparam int TIME_W  = 64;
  localparam int TOKEN_W = 30;
  localparam int CODE_W  = 30;
  localparam int STEP_W  = 31;
  localparam int KLEN_W  = 5;
  localparam int DIG_W   = 4;
  localparam int WIN_W   = 4;
  localparam int BIN_W   = 31;

  // Key storage and window limits
  localparam int KEY_BYTES   = 20;
  localparam int KEY_LEN_MAX = (KEY_BYTES < 20) ? KEY_BYTES : 20;
  localparam int MAX_WINDOW  = 15;
  localparam int MAG_W       = 4;

  // Shared step counter (divider bits, rounds, modulo bits)
  localparam int CNT_W       = 7;
  localparam int DIV_LAST    = TIME_W - 1;
  localparam int RND_LAST    = 79;
  localparam int MOD_LAST    = BIN_W;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_FIRST  = 3'd0;
  localparam logic [2:0] REG_KEY_MIDDLE = 3'd1;
  localparam logic [2:0] REG_KEY_LAST   = 3'd2;
  localparam logic [2:0] REG_KEY_LEN    = 3'd3;
  localparam logic [2:0] REG_STEP       = 3'd4;
  localparam logic [2:0] REG_DIGITS     = 3'd5;
  localparam logic [2:0] REG_WINDOW     = 3'd6;

  // Configuration reset values
  localparam logic [KLEN_W-1:0] KEY_LEN_RST = 5'd20;
  localparam logic [STEP_W-1:0] STEP_RST    = 31'd30;
  localparam logic [DIG_W-1:0]  DIGITS_RST  = 4'd6;
  localparam logic [WIN_W-1:0]  WINDOW_RST  = 4'd1;

  // HMAC pads
  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;

  // SHA-1 initial value
  localparam logic [31:0] SHA_IV0 = 32'h67452301;
  localparam logic [31:0] SHA_IV1 = 32'hEFCDAB89;
  localparam logic [31:0] SHA_IV2 = 32'h98BADCFE;
  localparam logic [31:0] SHA_IV3 = 32'h10325476;
  localparam logic [31:0] SHA_IV4 = 32'hC3D2E1F0;

  // Message lengths in bits of the two hashed messages
  localparam logic [63:0] INNER_BITS = 64'd576;
  localparam logic [63:0] OUTER_BITS = 64'd672;

  // Block select codes
  localparam logic [1:0] BLK_IPAD  = 2'd0;
  localparam logic [1:0] BLK_MSG   = 2'd1;
  localparam logic [1:0] BLK_OPAD  = 2'd2;
  localparam logic [1:0] BLK_INNER = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic             accept;
    logic             div_step;
    logic             blk_load;
    logic [1:0]       blk_sel;
    logic             h_init;
    logic             rnd_step;
    logic [CNT_W-1:0] rnd_idx;
    logic             h_add;
    logic             mod_load;
    logic             mod_step;
    logic             check;
    logic             out_load;
    logic             off_neg;
    logic [MAG_W-1:0] off_mag;
  } totp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic verify;
    logic hit;
    logic out_busy;
  } totp_sts_t;

  // Round constant of SHA-1
  function automatic logic [31:0] sha_k(input logic [CNT_W-1:0] idx);
    logic [31:0] k;
    if (idx < 7'd20)      k = 32'h5A827999;
    else if (idx < 7'd40) k = 32'h6ED9EBA1;
    else if (idx < 7'd60) k = 32'h8F1BBCDC;
    else                  k = 32'hCA62C1D6;
    return k;
  endfunction

  // Round function of SHA-1
  function automatic logic [31:0] sha_f(input logic [CNT_W-1:0] idx,
                                        input logic [31:0] b,
                                        input logic [31:0] c,
                                        input logic [31:0] d);
    logic [31:0] f;
    if (idx < 7'd20)      f = (b & c) | (~b & d);
    else if (idx < 7'd40) f = b ^ c ^ d;
    else if (idx < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                  f = b ^ c ^ d;
    return f;
  endfunction

  // Ten to the power of the saturated digit count
  function automatic logic [CODE_W-1:0] pow10(input logic [DIG_W-1:0] dig);
    logic [CODE_W-1:0] p;
    unique case (dig)
      4'd0, 4'd1: p = 30'd10;
      4'd2:       p = 30'd100;
      4'd3:       p = 30'd1000;
      4'd4:       p = 30'd10000;
      4'd5:       p = 30'd100000;
      4'd6:       p = 30'd1000000;
      4'd7:       p = 30'd10000000;
      4'd8:       p = 30'd100000000;
      default:    p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

FILE: src/totp_in_if.sv
`timescale 1ns / 1ps
// Input channel of the TOTP unit: action, time and token per beat.
interface totp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [totp_pkg::TIME_W-1:0]  unix_time;
  logic [totp_pkg::TOKEN_W-1:0] token;

  modport source (output valid, output action, output unix_time, output token,
                  input ready);
  modport sink (input valid, input action, input unix_time, input token,
                output ready);
endinterface

FILE: src/totp_out_if.sv
`timescale 1ns / 1ps
// Result channel of the TOTP unit: code and match flag per beat.
interface totp_out_if;
  logic                        valid;
  logic                        ready;
  logic [totp_pkg::CODE_W-1:0] code;
  logic                        match;

  modport source (output valid, output code, output match, input ready);
  modport sink (input valid, input code, input match, output ready);
endinterface

FILE: src/totp_dp.sv
`timescale 1ns / 1ps
// Datapath: time divider, SHA-1 round engine, truncation and modulo unit.
module totp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  totp_pkg::totp_cmd_t           cmd,
  output totp_pkg::totp_sts_t           sts,
  input  logic                          in_action,
  input  logic [totp_pkg::TIME_W-1:0]   in_unix_time,
  input  logic [totp_pkg::TOKEN_W-1:0]  in_token,
  input  logic [63:0]                   key_first,
  input  logic [63:0]                   key_middle,
  input  logic [31:0]                   key_last,
  input  logic [totp_pkg::KLEN_W-1:0]   key_len,
  input  logic [totp_pkg::STEP_W-1:0]   step_sec,
  input  logic [totp_pkg::DIG_W-1:0]    digit_cnt,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [totp_pkg::CODE_W-1:0]   out_code,
  output logic                          out_match
);

  // Item registers
  logic                         verify_r;
  logic [totp_pkg::TOKEN_W-1:0] token_r;

  // Divider
  logic [totp_pkg::STEP_W-1:0]  rem_r;
  logic [totp_pkg::TIME_W-1:0]  quo_r;
  logic [totp_pkg::STEP_W-1:0]  step_eff;
  logic [totp_pkg::STEP_W:0]    div_sh;
  logic                         div_ge;

  // SHA-1
  logic [31:0]                  w_r [16];
  logic [31:0]                  v_r [5];
  logic [31:0]                  h_r [5];
  logic [159:0]                 inner_r;
  logic [31:0]                  w_x;
  logic [31:0]                  w_new;
  logic [31:0]                  t_sum;
  logic [31:0]                  iv [5];

  // Blocks
  logic [511:0]                 kblk;
  logic [511:0]                 blk;
  logic [63:0]                  ctr;
  logic [totp_pkg::KLEN_W-1:0]  len_eff;
  logic [159:0]                 key_all;

  // Truncation and modulo
  logic [159:0]                 digest;
  logic [159:0]                 dig_sh;
  logic [totp_pkg::BIN_W-1:0]   bin_r;
  logic [totp_pkg::CODE_W-1:0]  mrem_r;
  logic [totp_pkg::CODE_W-1:0]  modulus;
  logic [totp_pkg::CODE_W:0]    mod_sh;
  logic                         mod_ge;

  // Results
  logic [totp_pkg::CODE_W-1:0]  code_r;
  logic                         match_r;
  logic                         out_valid_r;
  logic [totp_pkg::CODE_W-1:0]  out_code_r;
  logic                         out_match_r;

  assign iv[0] = totp_pkg::SHA_IV0;
  assign iv[1] = totp_pkg::SHA_IV1;
  assign iv[2] = totp_pkg::SHA_IV2;
  assign iv[3] = totp_pkg::SHA_IV3;
  assign iv[4] = totp_pkg::SHA_IV4;

  // Divider step: shift in one dividend bit, subtract when it fits
  assign step_eff = (step_sec == '0) ? {{(totp_pkg::STEP_W-1){1'b0}}, 1'b1} : step_sec;
  assign div_sh   = {rem_r, quo_r[totp_pkg::TIME_W-1]};
  assign div_ge   = div_sh >= {1'b0, step_eff};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      verify_r <= in_action;
      token_r  <= in_token;
      rem_r    <= '0;
      quo_r    <= in_unix_time;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? totp_pkg::STEP_W'(div_sh - {1'b0, step_eff})
                      : div_sh[totp_pkg::STEP_W-1:0];
      quo_r <= {quo_r[totp_pkg::TIME_W-2:0], div_ge};
    end
  end

  // Key block with zero padding beyond the key length
  assign key_all = {key_first, key_middle, key_last};
  assign len_eff = (key_len > totp_pkg::KLEN_W'(totp_pkg::KEY_LEN_MAX))
                   ? totp_pkg::KLEN_W'(totp_pkg::KEY_LEN_MAX) : key_len;

  always_comb begin
    kblk = '0;
    for (int i = 0; i < 20; i++) begin
      if (totp_pkg::KLEN_W'(i) < len_eff) kblk[511-8*i -: 8] = key_all[159-8*i -: 8];
    end
  end

  // Counter for the current window offset
  assign ctr = cmd.off_neg ? quo_r - {{(64-totp_pkg::MAG_W){1'b0}}, cmd.off_mag}
                           : quo_r + {{(64-totp_pkg::MAG_W){1'b0}}, cmd.off_mag};

  // Select the block to hash
  always_comb begin
    unique case (cmd.blk_sel)
      totp_pkg::BLK_IPAD:  blk = kblk ^ {64{totp_pkg::IPAD_BYTE}};
      totp_pkg::BLK_MSG:   blk = {ctr, 8'h80, 376'd0, totp_pkg::INNER_BITS};
      totp_pkg::BLK_OPAD:  blk = kblk ^ {64{totp_pkg::OPAD_BYTE}};
      default:             blk = {inner_r, 8'h80, 280'd0, totp_pkg::OUTER_BITS};
    endcase
  end

  // Schedule word and round sum
  assign w_x   = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new = {w_x[30:0], w_x[31]};
  assign t_sum = {v_r[0][26:0], v_r[0][31:27]}
               + totp_pkg::sha_f(cmd.rnd_idx, v_r[1], v_r[2], v_r[3])
               + v_r[4] + totp_pkg::sha_k(cmd.rnd_idx) + w_r[0];

  // Load block, run rounds, fold into chaining value
  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      for (int i = 0; i < 16; i++) w_r[i] <= blk[511-32*i -: 32];
      for (int i = 0; i < 5; i++) begin
        v_r[i] <= cmd.h_init ? iv[i] : h_r[i];
        if (cmd.h_init) h_r[i] <= iv[i];
      end
    end else if (cmd.rnd_step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[0]  <= t_sum;
      v_r[1]  <= v_r[0];
      v_r[2]  <= {v_r[1][1:0], v_r[1][31:2]};
      v_r[3]  <= v_r[2];
      v_r[4]  <= v_r[3];
    end else if (cmd.h_add) begin
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= h_r[i] + v_r[i];
        if (cmd.blk_sel == totp_pkg::BLK_MSG) inner_r[159-32*i -: 32] <= h_r[i] + v_r[i];
      end
    end
  end

  // Dynamic truncation: 31 bits at the byte offset named by the last nibble
  assign digest  = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
  assign dig_sh  = digest << {h_r[4][3:0], 3'b000};
  assign modulus = totp_pkg::pow10((digit_cnt > 4'd9) ? 4'd9 : digit_cnt);
  assign mod_sh  = {mrem_r, bin_r[totp_pkg::BIN_W-1]};
  assign mod_ge  = mod_sh >= {1'b0, modulus};

  // Bit-serial remainder by ten to the digit count
  always_ff @(posedge clk) begin
    if (cmd.mod_load) begin
      bin_r  <= dig_sh[158:128];
      mrem_r <= '0;
    end else if (cmd.mod_step) begin
      mrem_r <= mod_ge ? totp_pkg::CODE_W'(mod_sh - {1'b0, modulus})
                       : mod_sh[totp_pkg::CODE_W-1:0];
      bin_r  <= {bin_r[totp_pkg::BIN_W-2:0], 1'b0};
    end
  end

  assign sts.verify   = verify_r;
  assign sts.hit      = verify_r && (mrem_r == token_r);
  assign sts.out_busy = out_valid_r;

  // Hold code of offset zero and the match flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (cmd.accept) begin
      match_r <= 1'b0;
    end else if (cmd.check && sts.hit) begin
      match_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check && !cmd.off_neg && cmd.off_mag == '0) code_r <= mrem_r;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_code_r  <= code_r;
      out_match_r <= match_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_match = out_match_r;

endmodule

FILE: src/totp_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences divide, four compressions, modulo and window walk.
module totp_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [totp_pkg::WIN_W-1:0]  window,
  input  totp_pkg::totp_sts_t         sts,
  output totp_pkg::totp_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_MOD  = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]                 state_r, state_nxt;
  logic [totp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                 blk_r, blk_nxt;
  logic                       neg_r, neg_nxt;
  logic [totp_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic [totp_pkg::MAG_W-1:0] win_eff;

  // Saturate the window
  assign win_eff = (window > totp_pkg::WIN_W'(totp_pkg::MAX_WINDOW))
                   ? totp_pkg::MAG_W'(totp_pkg::MAX_WINDOW) : totp_pkg::MAG_W'(window);

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    blk_nxt     = blk_r;
    neg_nxt     = neg_r;
    mag_nxt     = mag_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.blk_sel = blk_r;
    cmd.rnd_idx = cnt_r;
    cmd.off_neg = neg_r;
    cmd.off_mag = mag_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_nxt    = '0;
          blk_nxt    = totp_pkg::BLK_IPAD;
          neg_nxt    = 1'b0;
          mag_nxt    = '0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == totp_pkg::CNT_W'(totp_pkg::DIV_LAST)) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.blk_load = 1'b1;
        cmd.h_init   = !blk_r[0];
        cnt_nxt      = '0;
        state_nxt    = S_RND;
      end
      S_RND: begin
        cmd.rnd_step = 1'b1;
        if (cnt_r == totp_pkg::CNT_W'(totp_pkg::RND_LAST)) begin
          state_nxt = S_ADD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ADD: begin
        cmd.h_add = 1'b1;
        blk_nxt   = blk_r + 1'b1;
        cnt_nxt   = '0;
        state_nxt = (blk_r == totp_pkg::BLK_INNER) ? S_MOD : S_LOAD;
      end
      S_MOD: begin
        cmd.mod_load = (cnt_r == '0);
        cmd.mod_step = (cnt_r != '0);
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == totp_pkg::CNT_W'(totp_pkg::MOD_LAST)) state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        if (!sts.verify || sts.hit || (!neg_r && mag_r >= win_eff)) begin
          state_nxt = S_OUT;
        end else begin
          // walk offsets: 0, -1, +1, -2, +2, ...
          neg_nxt   = !neg_r;
          mag_nxt   = neg_r ? mag_r : mag_r + 1'b1;
          blk_nxt   = totp_pkg::BLK_IPAD;
          state_nxt = S_LOAD;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      blk_r   <= '0;
      neg_r   <= 1'b0;
      mag_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      blk_r   <= blk_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_rnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND) |-> (cnt_r <= totp_pkg::CNT_W'(totp_pkg::RND_LAST)))
    else $error("round counter past last round");

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DIV && cnt_r == '0))
    else $error("accepted beat did not start divider");

  a_gen_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && !sts.verify) |=> (state_r == S_OUT))
    else $error("generate computed more than one code");

  a_last_blk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && blk_r == totp_pkg::BLK_INNER) |=> (state_r == S_MOD))
    else $error("outer hash did not end in modulo");
`endif

endmodule

FILE: src/time_based_one_time_password_unit.sv
`timescale 1ns / 1ps
// Top level of the TOTP unit: configuration registers, controller and datapath.
// Each input beat gives one result beat. An item computes one code for generate, and
// for verify from 1 up to 2*window+1 codes, stopping at the first match (offsets
// tried as 0, -1, +1, -2, +2 and so on). Around the codes come the hand-in, a bit-serial
// divide of the 64-bit time by the step, and the result hand-off; each code is four
// SHA-1 compressions of 80 rounds on a single one-round-per-cycle engine plus load
// and fold steps, and a bit-serial remainder of the 31-bit value by ten to the digit
// count. A finished result waits in an output register while the next item is
// accepted. Write configuration only while idle.
module time_based_one_time_password_unit (
  input  logic              clk,
  input  logic              rst_n,
  totp_in_if.sink           in_ch,
  totp_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [5:0]        cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [63:0]                  key_first_r;
  logic [63:0]                  key_middle_r;
  logic [31:0]                  key_last_r;
  logic [totp_pkg::KLEN_W-1:0]  key_len_r;
  logic [totp_pkg::STEP_W-1:0]  step_r;
  logic [totp_pkg::DIG_W-1:0]   digits_r;
  logic [totp_pkg::WIN_W-1:0]   window_r;
  logic [2:0]                   reg_idx;
  logic                         cfg_wr;
  totp_pkg::totp_cmd_t          cmd;
  totp_pkg::totp_sts_t          sts;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_first_r  <= '0;
      key_middle_r <= '0;
      key_last_r   <= '0;
      key_len_r    <= totp_pkg::KEY_LEN_RST;
      step_r       <= totp_pkg::STEP_RST;
      digits_r     <= totp_pkg::DIGITS_RST;
      window_r     <= totp_pkg::WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        totp_pkg::REG_KEY_FIRST:  key_first_r  <= cfg_pwdata;
        totp_pkg::REG_KEY_MIDDLE: key_middle_r <= cfg_pwdata;
        totp_pkg::REG_KEY_LAST:   key_last_r   <= cfg_pwdata[31:0];
        totp_pkg::REG_KEY_LEN:    key_len_r    <= cfg_pwdata[totp_pkg::KLEN_W-1:0];
        totp_pkg::REG_STEP:       step_r       <= cfg_pwdata[totp_pkg::STEP_W-1:0];
        totp_pkg::REG_DIGITS:     digits_r     <= cfg_pwdata[totp_pkg::DIG_W-1:0];
        totp_pkg::REG_WINDOW:     window_r     <= cfg_pwdata[totp_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      totp_pkg::REG_KEY_FIRST:  cfg_prdata = key_first_r;
      totp_pkg::REG_KEY_MIDDLE: cfg_prdata = key_middle_r;
      totp_pkg::REG_KEY_LAST:   cfg_prdata = {32'd0, key_last_r};
      totp_pkg::REG_KEY_LEN:    cfg_prdata = {{(64-totp_pkg::KLEN_W){1'b0}}, key_len_r};
      totp_pkg::REG_STEP:       cfg_prdata = {{(64-totp_pkg::STEP_W){1'b0}}, step_r};
      totp_pkg::REG_DIGITS:     cfg_prdata = {{(64-totp_pkg::DIG_W){1'b0}}, digits_r};
      totp_pkg::REG_WINDOW:     cfg_prdata = {{(64-totp_pkg::WIN_W){1'b0}}, window_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  totp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .window   (window_r),
    .sts      (sts),
    .cmd      (cmd)
  );

  totp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_action    (in_ch.action),
    .in_unix_time (in_ch.unix_time),
    .in_token     (in_ch.token),
    .key_first    (key_first_r),
    .key_middle   (key_middle_r),
    .key_last     (key_last_r),
    .key_len      (key_len_r),
    .step_sec     (step_r),
    .digit_cnt    (digits_r),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_code     (out_ch.code),
    .out_match    (out_ch.match)
  );

endmodule

FILE: sim/tb_time_based_one_time_password_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the TOTP unit: HMAC-SHA1 code predictor, APB setup, random traffic.
module tb_time_based_one_time_password_unit;

  localparam int LIMIT = 20000000;

  typedef struct {
    bit [totp_pkg::CODE_W-1:0] code;
    bit                        match;
  } otp_result_t;

  // Expected-code store with its own copy of the key and timing setup
  class otp_scoreboard;
    bit [63:0]                  key_first;
    bit [63:0]                  key_middle;
    bit [31:0]                  key_last;
    bit [totp_pkg::KLEN_W-1:0]  key_len;
    bit [totp_pkg::STEP_W-1:0]  step;
    bit [totp_pkg::DIG_W-1:0]   digits;
    bit [totp_pkg::WIN_W-1:0]   window;
    otp_result_t      pending_q[$];
    int n_checked, n_fail, n_gen, n_ver, n_hit;

    function new();
      key_first = '0; key_middle = '0; key_last = '0;
      key_len = totp_pkg::KEY_LEN_RST; step = totp_pkg::STEP_RST;
      digits = totp_pkg::DIGITS_RST; window = totp_pkg::WINDOW_RST;
    endfunction

    function void set_reg(bit [2:0] idx, bit [63:0] v);
      case (idx)
        totp_pkg::REG_KEY_FIRST:  key_first = v;
        totp_pkg::REG_KEY_MIDDLE: key_middle = v;
        totp_pkg::REG_KEY_LAST:   key_last = v[31:0];
        totp_pkg::REG_KEY_LEN:    key_len = v[totp_pkg::KLEN_W-1:0];
        totp_pkg::REG_STEP:       step = v[totp_pkg::STEP_W-1:0];
        totp_pkg::REG_DIGITS:     digits = v[totp_pkg::DIG_W-1:0];
        totp_pkg::REG_WINDOW:     window = v[totp_pkg::WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [159:0] compress(bit [159:0] h, bit [511:0] blk);
      bit [31:0] w[80];
      bit [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
      for (int i = 16; i < 80; i++) begin
        x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {x[30:0], x[31]};
      end
      a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = 32'h5A827999;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = 32'h6ED9EBA1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d; k = 32'hCA62C1D6;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    function bit [31:0] modulus();
      int dg;
      bit [31:0] m;
      dg = (digits == 0) ? 1 : (digits > 9) ? 9 : digits;
      m = 1;
      repeat (dg) m = m * 10;
      return m;
    endfunction

    function bit [63:0] step_count(bit [63:0] t);
      bit [63:0] s;
      s = (step == 0) ? 64'd1 : 64'(step);
      return t / s;
    endfunction

    // HMAC-SHA1 of the counter, dynamic truncation, reduction to the digit count
    function bit [totp_pkg::CODE_W-1:0] code_at(bit [63:0] ctr);
      bit [159:0] iv, key, inner, dig;
      bit [511:0] kblk, blk;
      bit [31:0]  bin;
      int len, off;
      iv = {totp_pkg::SHA_IV0, totp_pkg::SHA_IV1, totp_pkg::SHA_IV2,
            totp_pkg::SHA_IV3, totp_pkg::SHA_IV4};
      len = (key_len > totp_pkg::KEY_LEN_MAX) ? totp_pkg::KEY_LEN_MAX : key_len;
      key = {key_first, key_middle, key_last};
      for (int i = len; i < 20; i++) key[159-8*i -: 8] = 8'h00;
      kblk = {key, 352'b0};
      blk = {ctr, 8'h80, 376'b0, totp_pkg::INNER_BITS};
      inner = compress(compress(iv, kblk ^ {64{totp_pkg::IPAD_BYTE}}), blk);
      blk = {inner, 8'h80, 280'b0, totp_pkg::OUTER_BITS};
      dig = compress(compress(iv, kblk ^ {64{totp_pkg::OPAD_BYTE}}), blk);
      off = dig[3:0];
      bin = dig[159-8*off -: 32] & 32'h7FFFFFFF;
      return totp_pkg::CODE_W'(bin % modulus());
    endfunction

    function void note_input(bit act, bit [63:0] t, bit [totp_pkg::TOKEN_W-1:0] tok);
      otp_result_t r;
      bit [63:0] ctr;
      ctr = step_count(t);
      r.code = code_at(ctr);
      r.match = 0;
      if (act) begin
        n_ver++;
        if (r.code == tok) r.match = 1;
        for (int i = 1; i <= window && !r.match; i++)
          if (code_at(ctr - i) == tok || code_at(ctr + i) == tok) r.match = 1;
        if (r.match) n_hit++;
      end else begin
        n_gen++;
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(bit [totp_pkg::CODE_W-1:0] code, bit match);
      otp_result_t r;
      n_checked++;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: code %0d match %0d", code, match);
        n_fail++;
        return;
      end
      r = pending_q.pop_front();
      if (code !== r.code) begin
        $error("code: expected %0d, actual %0d", r.code, code);
        n_fail++;
      end
      if (match !== r.match) begin
        $error("match: expected %0d, actual %0d", r.match, match);
        n_fail++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  totp_in_if  in_ch ();
  totp_out_if out_ch ();

  time_based_one_time_password_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  otp_scoreboard sb = new();
  int  n_sent;
  int  cycles;
  bit  calm;
  bit  hold_req;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("time_based_one_time_password_unit: mismatch");
      $finish;
    end
  end

  // Observe beats on both channels
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.action, in_ch.unix_time, in_ch.token);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.code, out_ch.match);
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 3);
  endfunction

  // Result side: random stalls, one long hold-off on request
  initial begin
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 5000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Offer one beat, wait for it to be taken, then maybe pause
  task automatic send(bit act, bit [63:0] t, bit [totp_pkg::TOKEN_W-1:0] tok);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.unix_time <= t;
    in_ch.token <= tok;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every result is back and the block is quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.n_checked < n_sent) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(bit [2:0] idx, bit [63:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, v);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_all(bit [63:0] kf, bit [63:0] km, bit [31:0] kl, bit [4:0] len,
                         bit [30:0] stp, bit [3:0] dg, bit [3:0] win);
    cfg_write(totp_pkg::REG_KEY_FIRST, kf);
    cfg_write(totp_pkg::REG_KEY_MIDDLE, km);
    cfg_write(totp_pkg::REG_KEY_LAST, {32'b0, kl});
    cfg_write(totp_pkg::REG_KEY_LEN, {59'b0, len});
    cfg_write(totp_pkg::REG_STEP, {33'b0, stp});
    cfg_write(totp_pkg::REG_DIGITS, {60'b0, dg});
    cfg_write(totp_pkg::REG_WINDOW, {60'b0, win});
  endtask

  function automatic bit [63:0] rand_time();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return 64'($urandom);
      2: return $urandom_range(0, 1) ? 64'd0 : '1;
      3: return '1 - 64'($urandom_range(0, 100));
      default: return 64'($urandom_range(0, 200));
    endcase
  endfunction

  // Verify token: mostly a code inside the window, else noise or out of range
  function automatic bit [totp_pkg::TOKEN_W-1:0] rand_token(bit [63:0] t);
    int r, w, ofs;
    r = $urandom_range(0, 9);
    w = sb.window;
    if (r < 6) begin
      ofs = $urandom_range(0, 2 * w) - w;
      return sb.code_at(sb.step_count(t) + 64'(signed'(ofs)));
    end
    if (r < 8) return totp_pkg::TOKEN_W'($urandom % sb.modulus());
    if (r == 8) return totp_pkg::TOKEN_W'($urandom);
    return totp_pkg::TOKEN_W'($urandom_range(1000000000, (1 << 30) - 1));
  endfunction

  initial begin
    int n_items;
    bit [3:0] win;
    bit [63:0] t;
    bit act;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= 1'b0;
    in_ch.unix_time <= '0;
    in_ch.token <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    calm = 0;
    hold_req = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setup: zero key, default step and digits
    send(1'b0, 64'd0, '0);
    send(1'b0, '1, '1);
    send(1'b1, 64'd59, rand_token(64'd59));
    send(1'b1, 64'd100, totp_pkg::TOKEN_W'(1000000000));
    drain();

    // Standard 20-byte ASCII key, 8 digits
    cfg_all(64'h3132333435363738, 64'h3930313233343536, 32'h37383930, 5'd20,
            31'd30, 4'd8, 4'd1);
    send(1'b0, 64'd59, '0);
    send(1'b0, 64'd1111111109, '0);
    send(1'b0, 64'd20000000000, '0);
    send(1'b1, 64'd1234567890, rand_token(64'd1234567890));
    drain();
    // Index beyond the register list is ignored
    cfg_write(3'd7, '1);

    // Zero step, counter wrap at both ends, widest window, no match
    cfg_all('1, '1, '1, 5'd0, 31'd0, 4'd0, 4'd15);
    send(1'b1, 64'd0, rand_token(64'd0));
    send(1'b1, '1, rand_token('1));
    send(1'b1, 64'd5, totp_pkg::TOKEN_W'(1000000000));
    drain();
    cfg_all('0, '0, '0, 5'd31, 31'h7FFFFFFF, 4'd15, 4'd0);
    send(1'b0, '1, '0);
    send(1'b1, 64'd0, rand_token(64'd0));
    send(1'b1, 64'd42, '1);
    drain();
    cfg_all({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 5'd1, 31'd1, 4'd9, 4'd2);
    send(1'b1, '1, rand_token('1));
    send(1'b0, 64'd0, '0);
    drain();

    // Random phases with fresh setups
    for (int p = 0; p < 12; p++) begin
      win = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(3, 15));
      cfg_all({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
              5'($urandom_range(0, 31)),
              ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 2)) : 31'($urandom),
              4'($urandom_range(0, 15)), win);
      calm = (p == 2);
      n_items = (win > 2) ? 6 : 72;
      if (p == 3) begin
        // Hold results off while the sender keeps going
        calm = 1;
        hold_req = 1;
        for (int i = 0; i < 20; i++) send(1'b0, rand_time(), totp_pkg::TOKEN_W'($urandom));
        calm = 0;
      end
      for (int i = 0; i < n_items; i++) begin
        t = rand_time();
        act = $urandom_range(0, 1);
        send(act, t, act ? rand_token(t) : totp_pkg::TOKEN_W'($urandom));
      end
      drain();
      calm = 0;
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      $error("%0d results never arrived", sb.pending_q.size());
      sb.n_fail++;
    end
    $display("covered %0d generate and %0d verify beats, %0d verify hits",
             sb.n_gen, sb.n_ver, sb.n_hit);
    $display("key lengths, steps, digit counts and windows swept incl. extremes and wrap");
    if (sb.n_fail == 0) begin
      $display("time_based_one_time_password_unit: match");
    end else begin
      $display("time_based_one_time_password_unit: mismatch");
    end
    $finish;
  end

endmodule
